// ----- sv/vm_integer_execute_unit_defines.svh -----
// Assertion macros used by the port-level checker of the execute unit.
`ifndef VM_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define VM_INTEGER_EXECUTE_UNIT_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define VMX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked at every clock edge outside reset.
`define VMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/vmx_pkg.sv -----
// Package with opcodes, memory codes, states and the controller/datapath structs.
`default_nettype none
package vmx_pkg;
  localparam int unsigned DataW = 32;
  localparam logic [7:0] ByteMask = 8'hFF;

  typedef enum logic [5:0] {
    OP_MOV = 6'd0, OP_SET = 6'd3, OP_LD = 6'd5, OP_BLD = 6'd7, OP_ST = 6'd8,
    OP_BST = 6'd10, OP_ADD = 6'd11, OP_SUB = 6'd13, OP_MUL = 6'd15,
    OP_DIV = 6'd17, OP_MOD = 6'd19, OP_OR = 6'd20, OP_AND = 6'd21,
    OP_XOR = 6'd22, OP_NOT = 6'd23, OP_SHL = 6'd24, OP_SHR = 6'd25,
    OP_CMP = 6'h1A, OP_JZ = 6'd28, OP_JNZ = 6'd29, OP_JC = 6'd30,
    OP_JNC = 6'd31, OP_JBE = 6'd32, OP_JA = 6'd33, OP_JMP = 6'd34,
    OP_JMPR = 6'd35, OP_HALT = 6'h24, OP_RET = 6'd37
  } opcode_t;

  typedef enum logic [2:0] {
    MEM_NONE = 3'd0, MEM_RD_WORD = 3'd1, MEM_RD_BYTE = 3'd2,
    MEM_WR_WORD = 3'd3, MEM_WR_BYTE = 3'd4
  } mem_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;   // take the input beat
    logic read_ops;  // latch operands from the register file
    logic exec;      // operations other than div and mod
    logic div_start; // load the divider
    logic div_step;  // one quotient bit
    logic write;     // commit result and build output
  } dp_cmd_t;

  typedef struct packed {
    logic is_div;
    logic div_done;
  } dp_status_t;
endpackage
`default_nettype wire

// ----- sv/vmx_if.sv -----
// Valid/ready channel interfaces for instruction and result beats.
`default_nettype none
interface vmx_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  command;
  logic [3:0]  dst_reg;
  logic [3:0]  src_reg;
  logic [31:0] immediate;
  modport source (output valid, command, dst_reg, src_reg, immediate, input ready);
  modport sink (input valid, command, dst_reg, src_reg, immediate, output ready);
endinterface

interface vmx_out_if;
  logic        valid;
  logic        ready;
  logic        pc_load;
  logic [31:0] pc_target;
  logic [2:0]  mem_op;
  logic [31:0] mem_address;
  logic [31:0] mem_wdata;
  logic        zero_flag;
  logic        carry_flag;
  logic        div_error;
  logic        halted;
  modport source (output valid, pc_load, pc_target, mem_op, mem_address, mem_wdata,
                  zero_flag, carry_flag, div_error, halted, input ready);
  modport sink (input valid, pc_load, pc_target, mem_op, mem_address, mem_wdata,
                zero_flag, carry_flag, div_error, halted, output ready);
endinterface
`default_nettype wire

// ----- sv/vmx_ctrl.sv -----
// Controller state machine that sequences one instruction through the datapath.
`default_nettype none
module vmx_ctrl
  import vmx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_ops = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_WRITE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        // The output register frees as the beat leaves, so the next beat may enter.
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/vmx_datapath.sv -----
// Datapath: register file, flags, ALU, shared bit-serial divider, result register.
`default_nettype none
module vmx_datapath
  import vmx_pkg::*;
#(
  parameter int unsigned NUM_REGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic [5:0]  in_command,
  input  wire logic [3:0]  in_dst_reg,
  input  wire logic [3:0]  in_src_reg,
  input  wire logic [31:0] in_immediate,
  output logic             out_pc_load,
  output logic [31:0]      out_pc_target,
  output logic [2:0]       out_mem_op,
  output logic [31:0]      out_mem_address,
  output logic [31:0]      out_mem_wdata,
  output logic             out_zero_flag,
  output logic             out_carry_flag,
  output logic             out_div_error,
  output logic             out_halted
);
  localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [DataW-1:0] regs_r [NUM_REGS];
  logic             zero_r, carry_r, byte_pend_r;
  logic [5:0]       op_r;
  logic [3:0]       d_r, s_r;
  logic [31:0]      imm_r, a_r, b_r, res_r;
  logic             wr_en_r, wr_src_r, derr_r;
  logic [31:0]      quo_r, rem_r;
  logic [5:0]       cnt_r;
  logic [32:0]      rem_sh;
  logic [31:0]      a_rd, b_rd, diff;
  logic [31:0]      alu_res;
  logic             alu_wr, alu_to_src, take_jmp;
  logic             pc_load_nxt;
  logic [31:0]      pc_target_nxt, mem_addr_nxt, mem_wdata_nxt;
  mem_op_t          mem_op_nxt;

  assign diff = a_r - b_r;
  assign rem_sh = {rem_r, quo_r[31]};
  assign status.is_div = (op_r == OP_DIV) || (op_r == OP_MOD);
  assign status.div_done = (cnt_r == 6'd32) || (b_r == '0);

  function automatic logic [31:0] rd_reg(input logic [3:0] idx,
                                         input logic [DataW-1:0] rf [NUM_REGS]);
    logic [31:0] v;
    v = '0;
    if ({28'd0, idx} < 32'(NUM_REGS)) v = rf[IdxW'(idx)];
    return v;
  endfunction

  assign a_rd = rd_reg(d_r, regs_r);
  assign b_rd = rd_reg(s_r, regs_r);

  // ALU result and whether it goes back to the register file.
  always_comb begin
    alu_res    = '0;
    alu_wr     = 1'b1;
    alu_to_src = 1'b0;
    case (opcode_t'(op_r))
      OP_MOV: alu_res = b_r;
      OP_SET: alu_res = imm_r;
      OP_ADD: alu_res = a_r + b_r;
      OP_SUB: alu_res = diff;
      OP_MUL: alu_res = 32'(a_r * b_r);
      OP_OR:  alu_res = a_r | b_r;
      OP_AND: alu_res = a_r & b_r;
      OP_XOR: alu_res = a_r ^ b_r;
      OP_NOT: begin
        alu_res    = ~b_r;
        alu_to_src = 1'b1;
      end
      OP_SHL: alu_res = (b_r >= 32'd32) ? '0 : a_r << b_r[4:0];
      OP_SHR: alu_res = (b_r >= 32'd32) ? '0 : a_r >> b_r[4:0];
      OP_RET: alu_res = byte_pend_r ? {24'd0, imm_r[7:0] & ByteMask} : imm_r;
      default: alu_wr = 1'b0;
    endcase
  end

  // Jump and memory request fields of the result beat.
  always_comb begin
    take_jmp      = 1'b0;
    pc_load_nxt   = 1'b0;
    pc_target_nxt = '0;
    mem_op_nxt    = MEM_NONE;
    mem_addr_nxt  = '0;
    mem_wdata_nxt = '0;
    case (opcode_t'(op_r))
      OP_LD: begin
        mem_op_nxt   = MEM_RD_WORD;
        mem_addr_nxt = b_r;
      end
      OP_BLD: begin
        mem_op_nxt   = MEM_RD_BYTE;
        mem_addr_nxt = b_r;
      end
      OP_ST: begin
        mem_op_nxt    = MEM_WR_WORD;
        mem_addr_nxt  = a_r;
        mem_wdata_nxt = b_r;
      end
      OP_BST: begin
        mem_op_nxt    = MEM_WR_BYTE;
        mem_addr_nxt  = a_r;
        mem_wdata_nxt = {24'd0, b_r[7:0]};
      end
      OP_JZ:  take_jmp = zero_r;
      OP_JNZ: take_jmp = !zero_r;
      OP_JC:  take_jmp = carry_r;
      OP_JNC: take_jmp = !carry_r;
      OP_JBE: take_jmp = zero_r || carry_r;
      OP_JA:  take_jmp = carry_r && !zero_r;
      OP_JMP: take_jmp = 1'b1;
      OP_JMPR: begin
        pc_load_nxt   = 1'b1;
        pc_target_nxt = a_r;
      end
      default: take_jmp = 1'b0;
    endcase
    if (take_jmp) begin
      pc_load_nxt   = 1'b1;
      pc_target_nxt = imm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(NUM_REGS); i++) regs_r[i] <= '0;
      zero_r      <= 1'b0;
      carry_r     <= 1'b0;
      byte_pend_r <= 1'b0;
      wr_en_r     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op_r  <= in_command;
        d_r   <= in_dst_reg;
        s_r   <= in_src_reg;
        imm_r <= in_immediate;
      end
      if (cmd.read_ops) begin
        a_r <= a_rd;
        b_r <= b_rd;
      end
      if (cmd.div_start) begin
        quo_r   <= a_r;
        rem_r   <= '0;
        cnt_r   <= '0;
        wr_en_r <= (b_r != '0);
        derr_r  <= (b_r == '0);
        wr_src_r <= 1'b0;
      end
      if (cmd.div_step && !status.div_done) begin
        if (rem_sh >= {1'b0, b_r}) begin
          rem_r <= 32'(rem_sh - {1'b0, b_r});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
      end
      if (cmd.exec) begin
        wr_en_r  <= alu_wr;
        wr_src_r <= alu_to_src;
        derr_r   <= 1'b0;
        res_r    <= alu_res;
        if (op_r == OP_CMP) begin
          zero_r  <= (diff == '0);
          carry_r <= (diff != '0) && diff[31];
        end
        if (op_r == OP_LD || op_r == OP_RET) byte_pend_r <= 1'b0;
        if (op_r == OP_BLD) byte_pend_r <= 1'b1;
      end
      if (cmd.write) begin
        if (wr_en_r) begin
          if (wr_src_r) begin
            if ({28'd0, s_r} < 32'(NUM_REGS)) regs_r[IdxW'(s_r)] <= res_r;
          end else if ({28'd0, d_r} < 32'(NUM_REGS)) begin
            regs_r[IdxW'(d_r)] <= (op_r == OP_DIV) ? quo_r :
                                  (op_r == OP_MOD) ? rem_r : res_r;
          end
        end
        wr_en_r <= 1'b0;
      end
    end
  end

  // Result register, built at commit.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_pc_load     <= pc_load_nxt;
      out_pc_target   <= pc_target_nxt;
      out_mem_op      <= mem_op_nxt;
      out_mem_address <= mem_addr_nxt;
      out_mem_wdata   <= mem_wdata_nxt;
      out_halted      <= (op_r == OP_HALT);
      out_div_error   <= status.is_div && derr_r;
      out_zero_flag   <= zero_r;
      out_carry_flag  <= carry_r;
    end
  end
endmodule
`default_nettype wire

// ----- sv/vm_integer_execute_unit.sv -----
// An input beat passes the controller states read, exec and write before its result
// beat is offered in the out state; div and mod go from exec to the divider state,
// one quotient bit per cycle, and skip the division steps on a zero divisor. The next
// input beat is taken only as the result leaves; one instruction at a time.
// Reset (synchronous, rst_n low) clears the register file, both flags and the
// pending byte-load bit.
`default_nettype none
module vm_integer_execute_unit
  import vmx_pkg::*;
#(
  parameter int unsigned NUM_REGS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  vmx_in_if.sink   in_ch,
  vmx_out_if.source out_ch
);
  dp_cmd_t    cmd;
  dp_status_t status;

  vmx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vmx_datapath #(.NUM_REGS(NUM_REGS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_ch.command),
    .in_dst_reg      (in_ch.dst_reg),
    .in_src_reg      (in_ch.src_reg),
    .in_immediate    (in_ch.immediate),
    .out_pc_load     (out_ch.pc_load),
    .out_pc_target   (out_ch.pc_target),
    .out_mem_op      (out_ch.mem_op),
    .out_mem_address (out_ch.mem_address),
    .out_mem_wdata   (out_ch.mem_wdata),
    .out_zero_flag   (out_ch.zero_flag),
    .out_carry_flag  (out_ch.carry_flag),
    .out_div_error   (out_ch.div_error),
    .out_halted      (out_ch.halted)
  );
endmodule
`default_nettype wire

// ----- sv/vmx_checker.sv -----
// Port-level checker for the execute unit and its bind statement.
`default_nettype none
`include "vm_integer_execute_unit_defines.svh"
module vmx_checker
  import vmx_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       pc_load,
  input wire logic [31:0] pc_target,
  input wire logic [2:0] mem_op,
  input wire logic       div_error,
  input wire logic       halted
);
  // One instruction in flight: an accepted beat is never followed at once by a result.
  `VMX_ASSERT_NEXT(a_no_fast, in_valid && in_ready, !out_valid, "result too early")
  `VMX_ASSERT_IMPL(a_busy, out_valid && !out_ready, !in_ready, "input taken while result stalls")
  `VMX_ASSERT_IMPL(a_excl, out_valid, !(pc_load && mem_op != MEM_NONE), "jump with memory request")
  `VMX_ASSERT_IMPL(a_nopc, out_valid && !pc_load, pc_target == 32'd0, "stray target")
  `VMX_ASSERT_IMPL(a_halt, out_valid && halted, !div_error && !pc_load, "halt with side effect")
endmodule

bind vm_integer_execute_unit vmx_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pc_load   (out_ch.pc_load),
  .pc_target (out_ch.pc_target),
  .mem_op    (out_ch.mem_op),
  .div_error (out_ch.div_error),
  .halted    (out_ch.halted)
);
`default_nettype wire

// ----- verif/vm_integer_execute_unit_checker.sv -----
// Checker for the execute unit: predicts each result beat and compares it.
`timescale 1ns / 1ps
module vm_integer_execute_unit_checker
  import vmx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  vmx_in_if.sink     in_mon,
  vmx_out_if.sink    out_mon,
  output int         fail_count,
  output int         pending_count
);
  typedef struct packed {
    logic        pc_load;
    logic [31:0] pc_target;
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] mem_wdata;
    logic        zero_flag;
    logic        carry_flag;
    logic        div_error;
    logic        halted;
  } exec_result_t;

  logic [31:0] regs_m [16];
  logic zf_m, cf_m, byte_ld_m;
  exec_result_t expected_results[$];

  assign pending_count = expected_results.size();

  // Executes one instruction on the shadow machine state and returns its result.
  function automatic exec_result_t execute_instr(logic [5:0] cmd, logic [3:0] d,
                                                 logic [3:0] s, logic [31:0] imm);
    exec_result_t r;
    logic [31:0] a, b, diff;
    logic take;
    r = '0;
    a = regs_m[d];
    b = regs_m[s];
    take = 1'b0;
    case (cmd)
      OP_MOV: regs_m[d] = b;
      OP_SET: regs_m[d] = imm;
      OP_LD: begin r.mem_op = MEM_RD_WORD; r.mem_address = b; byte_ld_m = 1'b0; end
      OP_BLD: begin r.mem_op = MEM_RD_BYTE; r.mem_address = b; byte_ld_m = 1'b1; end
      OP_ST: begin r.mem_op = MEM_WR_WORD; r.mem_address = a; r.mem_wdata = b; end
      OP_BST: begin
        r.mem_op = MEM_WR_BYTE; r.mem_address = a; r.mem_wdata = {24'd0, b[7:0]};
      end
      OP_ADD: regs_m[d] = a + b;
      OP_SUB: regs_m[d] = a - b;
      OP_MUL: regs_m[d] = a * b;
      OP_DIV: if (b == 0) r.div_error = 1'b1; else regs_m[d] = a / b;
      OP_MOD: if (b == 0) r.div_error = 1'b1; else regs_m[d] = a % b;
      OP_OR:  regs_m[d] = a | b;
      OP_AND: regs_m[d] = a & b;
      OP_XOR: regs_m[d] = a ^ b;
      OP_NOT: regs_m[s] = ~b;
      OP_SHL: regs_m[d] = (b >= 32) ? 32'd0 : a << b[4:0];
      OP_SHR: regs_m[d] = (b >= 32) ? 32'd0 : a >> b[4:0];
      OP_CMP: begin
        diff = a - b;
        zf_m = (diff == 0);
        cf_m = (diff != 0) && diff[31];
      end
      OP_JZ:  take = zf_m;
      OP_JNZ: take = !zf_m;
      OP_JC:  take = cf_m;
      OP_JNC: take = !cf_m;
      OP_JBE: take = zf_m || cf_m;
      OP_JA:  take = cf_m && !zf_m;
      OP_JMP: take = 1'b1;
      OP_JMPR: begin r.pc_load = 1'b1; r.pc_target = a; end
      OP_HALT: r.halted = 1'b1;
      OP_RET: begin
        regs_m[d] = byte_ld_m ? {24'd0, imm[7:0]} : imm;
        byte_ld_m = 1'b0;
      end
      default: ;
    endcase
    if (take) begin
      r.pc_load = 1'b1;
      r.pc_target = imm;
    end
    r.zero_flag = zf_m;
    r.carry_flag = cf_m;
    return r;
  endfunction

  always @(posedge clk) begin
    exec_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs_m[i] <= '0;
      zf_m <= 1'b0;
      cf_m <= 1'b0;
      byte_ld_m <= 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // Compare first so that a same-edge input beat cannot satisfy itself.
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pc_load, out_mon.pc_target, out_mon.mem_op, out_mon.mem_address,
                out_mon.mem_wdata, out_mon.zero_flag, out_mon.carry_flag,
                out_mon.div_error, out_mon.halted};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(execute_instr(in_mon.command, in_mon.dst_reg,
                                                 in_mon.src_reg, in_mon.immediate));
    end
  end
endmodule

// ----- verif/vm_integer_execute_unit_tb.sv -----
// Testbench top: drives instructions and result backpressure, gives the verdict.
`timescale 1ns / 1ps
module vm_integer_execute_unit_tb;
  import vmx_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count, pending_count;
  logic long_stall = 1'b0;
  logic hold_req = 1'b0;
  logic stall_on = 1'b0;

  vmx_in_if  in_ch();
  vmx_out_if out_ch();

  vm_integer_execute_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  vm_integer_execute_unit_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch),
                                       .out_mon(out_ch), .fail_count(fail_count),
                                       .pending_count(pending_count));

  always #1 clk = ~clk;

  localparam opcode_t OpList[28] = '{OP_MOV, OP_SET, OP_LD, OP_BLD, OP_ST, OP_BST, OP_ADD,
    OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR, OP_NOT, OP_SHL, OP_SHR, OP_CMP,
    OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_JBE, OP_JA, OP_JMP, OP_JMPR, OP_HALT, OP_RET};

  // Sends one instruction beat and waits for it to be accepted.
  task automatic send_instr(logic [5:0] cmd, logic [3:0] d, logic [3:0] s,
                            logic [31:0] imm);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.dst_reg <= d;
    in_ch.src_reg <= s;
    in_ch.immediate <= imm;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 40);
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random instruction: mostly a defined opcode, sometimes an undefined one,
  // with div and mod kept rarer because they are slow.
  task automatic send_random();
    logic [5:0] cmd;
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) cmd = 6'($urandom_range(38, 63));
    else if (k < 7) cmd = 6'd2;
    else begin
      cmd = OpList[$urandom_range(0, 27)];
      if ((cmd == OP_DIV || cmd == OP_MOD) && $urandom_range(0, 2) != 0) cmd = OP_ADD;
    end
    if (cmd == OP_LD || cmd == OP_BLD) begin
      send_instr(cmd, 4'($urandom), 4'($urandom), $urandom);
      send_instr(OP_RET, 4'($urandom), 4'($urandom), $urandom);
    end else if ($urandom_range(0, 3) == 0) begin
      send_instr(OP_SET, 4'($urandom), 4'($urandom), rand_value());
    end else begin
      send_instr(cmd, 4'($urandom), 4'($urandom), $urandom);
    end
  endtask

  // Receiver: always ready or a random stall pattern, overridden by a long hold-off.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (long_stall) out_ch.ready <= 1'b0;
    else if (stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  initial begin
    int guard;
    in_ch.valid = 1'b0;
    in_ch.command = OP_MOV;
    in_ch.dst_reg = '0;
    in_ch.src_reg = '0;
    in_ch.immediate = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every opcode, and the special cases.
    send_instr(OP_SET, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_instr(OP_SET, 4'd15, 4'd0, 32'd0);
    send_instr(OP_DIV, 4'd0, 4'd15, 32'd0);
    send_instr(OP_MOD, 4'd0, 4'd15, 32'd0);
    send_instr(OP_SET, 4'd1, 4'd0, 32'd32);
    send_instr(OP_SHL, 4'd0, 4'd1, 32'd0);
    send_instr(OP_SHR, 4'd0, 4'd1, 32'd0);
    send_instr(OP_BLD, 4'd3, 4'd0, 32'd0);
    send_instr(OP_RET, 4'd2, 4'd0, 32'hDEAD_BEEF);
    send_instr(OP_LD, 4'd3, 4'd2, 32'd0);
    send_instr(OP_RET, 4'd4, 4'd0, 32'hCAFE_F00D);
    send_instr(OP_BST, 4'd4, 4'd2, 32'd0);
    send_instr(OP_ST, 4'd2, 4'd4, 32'd0);
    send_instr(OP_CMP, 4'd15, 4'd4, 32'd0);
    send_instr(OP_JA, 4'd0, 4'd0, 32'h1234_5678);
    send_instr(OP_CMP, 4'd2, 4'd2, 32'd0);
    send_instr(OP_JBE, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_instr(OP_JMPR, 4'd4, 4'd0, 32'd0);
    send_instr(OP_NOT, 4'd0, 4'd15, 32'd0);
    send_instr(6'd2, 4'd0, 4'd0, 32'd0);
    send_instr(6'd63, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_instr(OP_HALT, 4'd0, 4'd0, 32'd0);
    for (int i = 0; i < 28; i++) send_instr(OpList[i], 4'($urandom), 4'($urandom), $urandom);

    stall_on <= 1'b1;
    for (int n = 0; n < 500; n++) begin
      if (n == 150) hold_req <= 1'b1;
      if (n == 300) begin
        // Sender pause until the block has drained.
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      if (n == 400) stall_on <= 1'b0;
      if (n == 450) stall_on <= 1'b1;
      send_random();
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 6));
    end
    in_ch.valid <= 1'b0;

    guard = 0;
    while (pending_count != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("vm_integer_execute_unit_tb passed");
    end else begin
      $display("vm_integer_execute_unit_tb failed");
    end
    $finish;
  end

  // Long receiver hold-off counted in its own process.
  initial begin
    wait (hold_req);
    long_stall <= 1'b1;
    repeat (300) @(negedge clk);
    long_stall <= 1'b0;
  end

  initial begin
    #2000000;
    $display("vm_integer_execute_unit_tb failed");
    $finish;
  end
endmodule
